// ===== sv/rip_pkg.sv =====
// Package for the radix integer parser: shared types, phase codes, register
// indexes, character helpers and result limits.
// No dependencies.
package rip_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned END_W      = 12;
    localparam int unsigned BASE_W     = 6;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 80;   // 78 bits of fields padded to whole bytes

    // Parse phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_SIGNED = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_ZEROX  = 3'd4;
    localparam logic [2:0] PH_DIGITS = 3'd5;
    localparam logic [2:0] PH_DRAIN  = 3'd6;

    // Register indexes on the configuration port
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_KIND  = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_S32 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_S64 = 2'd1;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [BASE_W-1:0] NO_DIGIT  = 6'd63;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;

    localparam logic [VALUE_W-1:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
    localparam logic [VALUE_W-1:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
    localparam logic [VALUE_W-1:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [BASE_W-1:0] radix;
        logic [KIND_W-1:0] kind;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic [VALUE_W-1:0] acc;
        logic               negative;
        logic [BASE_W-1:0]  wbase;
        logic               saturated;
        logic [KIND_W-1:0]  kind;
    } state_t;

    typedef struct packed {
        logic               bad_base;
        logic               overflowed;
        logic [END_W-1:0]   end_offset;
        logic [VALUE_W-1:0] value;
    } res_t;

    function automatic logic [BASE_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [BASE_W-1:0] d;
        d = NO_DIGIT;
        if (c >= 8'h30 && c <= 8'h39)
            d = BASE_W'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h5A)
            d = BASE_W'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h7A)
            d = BASE_W'(c - 8'h57);
        return d;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic kind_signed(input logic [KIND_W-1:0] k);
        return (k == KIND_S32) || (k == KIND_S64);
    endfunction

    function automatic logic [VALUE_W-1:0] kind_limit(input logic [KIND_W-1:0] k,
                                                      input logic neg);
        logic [VALUE_W-1:0] l;
        case (k)
            KIND_S32: l = neg ? LIM_S32_NEG : LIM_S32_POS;
            KIND_S64: l = neg ? LIM_S64_NEG : LIM_S64_POS;
            default:  l = LIM_U64;
        endcase
        return l;
    endfunction

endpackage

// ===== sv/radix_integer_parser_unit.sv =====
// Top level of the radix integer parser: stream ports, input and result
// registers, parse state. Depends on rip_pkg, rip_apb_regs and rip_step.
//
// Streaming string-to-integer converter in the strtol manner. Send one
// character per transfer on the slave side; a string ends with a zero
// character. Leading white space is skipped, an optional sign is taken (only
// '+' in the unsigned kind), a 0x/0X prefix is honoured only when a hex digit
// follows it, and base 0 picks octal after a leading zero, else decimal.
// Digits of base 2 to 36 accumulate with saturation at the signed 32-bit,
// signed 64-bit or unsigned 64-bit limit. Exactly one result transfer leaves
// per string, on the character that ends the number: the value (sign-extended
// two's complement in signed kinds), the offset of that character (0 when no
// digits were seen), an overflow flag and an illegal-base flag. An illegal
// base gives its result on the first character. Radix and result kind are
// latched on each string's first character; write them between strings.
// Throughput is one character per clock cycle while results are not stalled:
// a character held in the input register is resolved by the step logic,
// whose longest path is a 64-by-6-bit multiply-add and limit compare, and
// the outcome lands in the result register, from which it is presented.
// A waiting result does not stop the next character entering the input
// register; only a full input register and a stalled result hold tready low.
module radix_integer_parser_unit
    import rip_pkg::*;
#(
    parameter int unsigned OFFSET_LIMIT = 4095
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // character stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] ch
    // result stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [63:0] value, [75:64] end_offset,
                                            // [76] overflowed, [77] bad_base, rest 0
);

    localparam int unsigned POS_W = $clog2(OFFSET_LIMIT + 1);

    cfg_t               cfg;
    logic               in_valid_reg;
    logic [CH_W-1:0]    in_ch_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_t               out_res_reg;
    state_t             state_reg;
    state_t             state_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [POS_W-1:0]   zoff_reg;
    logic [POS_W-1:0]   zoff_next;
    logic               emit;
    res_t               res;
    logic               advance;
    logic               take_in;

    rip_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rip_step #(
        .OFFSET_LIMIT (OFFSET_LIMIT)
    ) u_step (
        .ch        (in_ch_reg),
        .cfg       (cfg),
        .st        (state_reg),
        .pos       (pos_reg),
        .zoff      (zoff_reg),
        .st_next   (state_next),
        .pos_next  (pos_next),
        .zoff_next (zoff_next),
        .emit      (emit),
        .res       (res)
    );

    // Advance the held character once the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            pos_reg       <= '0;
            zoff_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
                zoff_reg  <= zoff_next;
            end
        end
    end

    // Payload registers: hold the character and the result without reset
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_ch_reg <= s_tdata[CH_W-1:0];
        if (advance && emit)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_res_reg);

endmodule

// ===== sv/rip_apb_regs.sv =====
// Configuration registers of the radix integer parser behind an APB-style port.
// Depends on rip_pkg.
module rip_apb_regs
    import rip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_RADIX: cfg_reg.radix <= pwdata[BASE_W-1:0];
                REG_KIND:  cfg_reg.kind  <= pwdata[KIND_W-1:0];
                default:   cfg_reg       <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RADIX: prdata = 32'(cfg_reg.radix);
            REG_KIND:  prdata = 32'(cfg_reg.kind);
            default:   prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/rip_step.sv =====
// Next-state and result logic of the radix integer parser for one character.
// Depends on rip_pkg.
module rip_step
    import rip_pkg::*;
#(
    parameter int unsigned OFFSET_LIMIT = 4095
)
(
    input  logic [CH_W-1:0]                      ch,
    input  cfg_t                                 cfg,
    input  state_t                               st,
    input  logic [$clog2(OFFSET_LIMIT+1)-1:0]    pos,
    input  logic [$clog2(OFFSET_LIMIT+1)-1:0]    zoff,
    output state_t                               st_next,
    output logic [$clog2(OFFSET_LIMIT+1)-1:0]    pos_next,
    output logic [$clog2(OFFSET_LIMIT+1)-1:0]    zoff_next,
    output logic                                 emit,
    output res_t                                 res
);

    localparam int unsigned POS_W = $clog2(OFFSET_LIMIT + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(OFFSET_LIMIT);

    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   zoff_inc;
    logic [BASE_W-1:0]  dig;
    logic [69:0]        mul;

    assign pos_inc  = (pos >= POS_MAX) ? POS_MAX : pos + POS_W'(1);
    assign zoff_inc = (zoff >= POS_MAX) ? POS_MAX : zoff + POS_W'(1);
    assign dig      = digit_of(ch);

    always_comb
    begin
        state_t             s;
        logic [2:0]         ph;
        logic               done;
        logic               do_dig;
        logic               any;
        logic               clr;
        logic [VALUE_W-1:0] lim;
        logic [VALUE_W-1:0] mag;
        logic [70:0]        sum;

        s         = st;
        ph        = st.phase;
        pos_next  = pos;
        zoff_next = zoff;
        done      = 1'b0;
        do_dig    = 1'b0;
        any       = 1'b0;
        clr       = 1'b0;
        emit      = 1'b0;
        res       = '0;
        lim       = '0;
        mag       = '0;
        sum       = '0;
        mul       = '0;

        // Latch the registers on the first character of a string
        if (ph == PH_IDLE)
        begin
            s.wbase = cfg.radix;
            s.kind  = cfg.kind;
            if (cfg.radix == BASE_ONE || cfg.radix > BASE_MAX)
            begin
                emit         = 1'b1;
                res.bad_base = 1'b1;
                clr          = (ch == CH_NUL);
                done         = 1'b1;
            end
            else
            begin
                ph = PH_SPACE;
            end
        end

        if (!done && ph == PH_SPACE)
        begin
            if (is_space(ch))
            begin
                pos_next = pos_inc;
                done     = 1'b1;
            end
            else
            begin
                ph = PH_SIGNED;
                if (ch == CH_PLUS || (ch == CH_MINUS && kind_signed(s.kind)))
                begin
                    s.negative = (ch == CH_MINUS);
                    pos_next   = pos_inc;
                    done       = 1'b1;
                end
            end
        end

        if (!done && ph == PH_SIGNED)
        begin
            if (ch == CH_ZERO && (s.wbase == BASE_AUTO || s.wbase == BASE_HEX))
            begin
                zoff_next = pos;
                ph        = PH_ZERO;
                pos_next  = pos_inc;
                done      = 1'b1;
            end
            else
            begin
                if (s.wbase == BASE_AUTO)
                    s.wbase = BASE_DEC;
                do_dig = 1'b1;
                done   = 1'b1;
            end
        end

        if (!done && ph == PH_ZERO)
        begin
            if (ch == CH_LX || ch == CH_UX)
            begin
                ph       = PH_ZEROX;
                pos_next = pos_inc;
            end
            else
            begin
                if (s.wbase == BASE_AUTO)
                    s.wbase = BASE_OCT;
                s.acc  = '0;
                do_dig = 1'b1;
                any    = 1'b1;
            end
            done = 1'b1;
        end

        if (!done && ph == PH_ZEROX)
        begin
            if (dig < BASE_HEX)
            begin
                s.wbase = BASE_HEX;
                do_dig  = 1'b1;
            end
            else
            begin
                // Prefix with no hex digit: just the zero, ending at the x
                emit           = 1'b1;
                res.end_offset = END_W'(zoff_inc);
                clr            = (ch == CH_NUL);
            end
            done = 1'b1;
        end

        if (!done && ph == PH_DIGITS)
        begin
            do_dig = 1'b1;
            any    = 1'b1;
            done   = 1'b1;
        end

        if (!done)
            clr = (ch == CH_NUL);

        // Accumulate one digit, saturating at the kind's limit
        if (do_dig)
        begin
            lim = kind_limit(s.kind, s.negative);
            mul = 70'(s.acc) * 70'(s.wbase);
            sum = 71'(mul) + 71'(dig);
            if (s.wbase >= 6'd2 && s.wbase <= BASE_MAX && dig < s.wbase)
            begin
                if (s.saturated || sum > 71'(lim))
                    s.saturated = 1'b1;
                else
                    s.acc = sum[VALUE_W-1:0];
                ph       = PH_DIGITS;
                pos_next = pos_inc;
            end
            else
            begin
                emit = 1'b1;
                if (any)
                begin
                    mag            = s.saturated ? lim : s.acc;
                    res.value      = s.negative ? (~mag + VALUE_W'(1)) : mag;
                    res.end_offset = END_W'(pos);
                    res.overflowed = s.saturated;
                end
                clr = (ch == CH_NUL);
            end
        end

        if (emit && !clr)
            ph = PH_DRAIN;

        s.phase = ph;

        if (clr)
        begin
            s         = '0;
            s.phase   = PH_IDLE;
            pos_next  = '0;
            zoff_next = '0;
        end

        st_next = s;
    end

endmodule

// ===== sv/rip_checker.sv =====
// Port-level checks for the radix integer parser, bound to the top level.
// Depends on rip_pkg and radix_integer_parser_unit.
module rip_checker
    import rip_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transfer dropped or changed");

    // An illegal base carries nothing else
    a_bad_base_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[77] |-> m_tdata[76:0] == 77'd0)
        else $error("illegal-base result carries a value, offset or overflow");

    // A saturated result is one of the kind limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[76] |->
            m_tdata[63:0] == LIM_S32_POS || m_tdata[63:0] == 64'hFFFF_FFFF_8000_0000 ||
            m_tdata[63:0] == LIM_S64_POS || m_tdata[63:0] == LIM_S64_NEG ||
            m_tdata[63:0] == LIM_U64)
        else $error("overflowed result is not a saturation limit");

    // An overflow implies digits, so no illegal-base flag and zero padding
    a_sat_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[76] |-> !m_tdata[77] && m_tdata[79:78] == 2'b00)
        else $error("overflowed result flags an illegal base or padding");

endmodule

bind radix_integer_parser_unit rip_checker u_rip_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb_radix_integer_parser_unit.sv =====
// Self-checking bench for radix_integer_parser_unit: streams character strings in,
// predicts each parse result and checks every result transfer field by field.
// Depends on rip_pkg and the radix_integer_parser_unit RTL.
module tb_radix_integer_parser_unit;
    import rip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OFFSET_CAP    = 4095;
    localparam int unsigned PHASE_CHARS   = 64;    // characters per random phase
    localparam int unsigned SETTLE_CYCLES = 8;     // settling time after the streams drain
    localparam int unsigned STALL_LIMIT   = 5000;  // cycles without any transfer
    localparam int unsigned LONG_BLANKS   = 40;

    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

    // Clock, reset and block inputs, all known from time zero
    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [2:0]           paddr   = '0;
    logic [31:0]          pwdata  = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    radix_integer_parser_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [7:0] ch
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)      // [63:0] value, [75:64] end_offset, [76] overflowed,
                                 // [77] bad_base, [79:78] zero
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Characters waiting to be sent, and results the parser owes us
    logic [CH_W-1:0] pending_chars[$];
    res_t            due_results[$];
    int unsigned     chars_queued = 0;
    int unsigned     chars_taken  = 0;
    int unsigned     mismatches   = 0;
    int unsigned     stall_cycles = 0;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    bit              char_taken   = 1'b0;

    logic [CH_W-1:0] blanks[6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};

    // Parser image: configuration as written, plus the per-string state
    logic [BASE_W-1:0]  cfg_radix = BASE_AUTO;
    logic [KIND_W-1:0]  cfg_kind  = KIND_S32;
    logic [2:0]         parse_phase;
    logic [VALUE_W-1:0] mag_acc;
    logic               neg_sign;
    logic [BASE_W-1:0]  work_base;
    logic               clipped;
    logic [END_W-1:0]   char_pos;
    logic [END_W-1:0]   zero_pos;
    logic [KIND_W-1:0]  live_kind;

    function automatic logic [BASE_W-1:0] char_digit(input logic [CH_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return BASE_W'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h5A)
            return BASE_W'(c - 8'h41 + 8'd10);
        if (c >= 8'h61 && c <= 8'h7A)
            return BASE_W'(c - 8'h61 + 8'd10);
        return NO_DIGIT;
    endfunction

    function automatic bit is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [END_W-1:0] sat_next(input logic [END_W-1:0] p);
        return (p >= END_W'(OFFSET_CAP)) ? END_W'(OFFSET_CAP) : p + END_W'(1);
    endfunction

    // Saturation bound for the latched kind and the sign seen so far
    function automatic logic [VALUE_W-1:0] clip_bound();
        case (live_kind)
            KIND_S32: return neg_sign ? LIM_S32_NEG : LIM_S32_POS;
            KIND_S64: return neg_sign ? LIM_S64_NEG : LIM_S64_POS;
            default:  return LIM_U64;
        endcase
    endfunction

    function automatic void clear_parse();
        parse_phase = PH_IDLE;
        mag_acc     = '0;
        neg_sign    = 1'b0;
        work_base   = BASE_AUTO;
        clipped     = 1'b0;
        char_pos    = '0;
        zero_pos    = '0;
        live_kind   = KIND_S32;
    endfunction

    // After a result: a terminator starts afresh, anything else is skipped to it
    function automatic void close_number(input logic [CH_W-1:0] c);
        if (c == CH_NUL)
            clear_parse();
        else
            parse_phase = PH_DRAIN;
    endfunction

    function automatic bit take_digit(input logic [CH_W-1:0] c, input bit had_digits,
                                      output res_t r);
        logic [BASE_W-1:0]  d;
        logic [VALUE_W-1:0] bound;
        logic [VALUE_W-1:0] cut;
        logic [VALUE_W-1:0] cut_rem;
        logic [VALUE_W-1:0] v;
        r     = '0;
        d     = char_digit(c);
        bound = clip_bound();
        if (work_base >= 2 && work_base <= BASE_MAX && d < work_base) begin
            cut     = bound / work_base;
            cut_rem = bound % work_base;
            if (clipped || mag_acc > cut || (mag_acc == cut && d > cut_rem))
                clipped = 1'b1;
            else
                mag_acc = mag_acc * work_base + d;
            parse_phase = PH_DIGITS;
            char_pos    = sat_next(char_pos);
            return 1'b0;
        end
        if (had_digits) begin
            v = clipped ? bound : mag_acc;
            if (neg_sign)
                v = '0 - v;
            r.value      = v;
            r.end_offset = char_pos;
            r.overflowed = clipped;
        end
        close_number(c);
        return 1'b1;
    endfunction

    // Advance the parser image by one character; return 1 when a result is due
    function automatic bit parse_char(input logic [CH_W-1:0] c, output res_t r);
        r = '0;
        if (parse_phase == PH_IDLE) begin
            work_base = cfg_radix;
            live_kind = cfg_kind;
            if (work_base == BASE_ONE || work_base > BASE_MAX) begin
                r.bad_base = 1'b1;
                close_number(c);
                return 1'b1;
            end
            parse_phase = PH_SPACE;
        end
        if (parse_phase == PH_SPACE) begin
            if (is_blank(c)) begin
                char_pos = sat_next(char_pos);
                return 1'b0;
            end
            parse_phase = PH_SIGNED;
            // a minus is no sign at all in the unsigned kinds
            if (c == CH_PLUS ||
                (c == CH_MINUS && (live_kind == KIND_S32 || live_kind == KIND_S64))) begin
                neg_sign = (c == CH_MINUS);
                char_pos = sat_next(char_pos);
                return 1'b0;
            end
        end
        if (parse_phase == PH_SIGNED) begin
            if (c == CH_ZERO && (work_base == BASE_AUTO || work_base == BASE_HEX)) begin
                zero_pos    = char_pos;
                parse_phase = PH_ZERO;
                char_pos    = sat_next(char_pos);
                return 1'b0;
            end
            if (work_base == BASE_AUTO)
                work_base = BASE_DEC;
            return take_digit(c, 1'b0, r);
        end
        if (parse_phase == PH_ZERO) begin
            if (c == CH_LX || c == CH_UX) begin
                parse_phase = PH_ZEROX;
                char_pos    = sat_next(char_pos);
                return 1'b0;
            end
            if (work_base == BASE_AUTO)
                work_base = BASE_OCT;
            mag_acc = '0;
            return take_digit(c, 1'b1, r);
        end
        if (parse_phase == PH_ZEROX) begin
            if (char_digit(c) < 16) begin
                work_base = BASE_HEX;
                return take_digit(c, 1'b0, r);
            end
            // prefix with no hex digit behind it: the lone zero, ending at the x
            r.end_offset = sat_next(zero_pos);
            close_number(c);
            return 1'b1;
        end
        if (parse_phase == PH_DIGITS)
            return take_digit(c, 1'b1, r);
        if (c == CH_NUL)
            clear_parse();
        return 1'b0;
    endfunction

    // Driver: present the next character at the falling edge, hold it until taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!s_tvalid || char_taken) begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: sample both streams at the rising edge, predict and check
    always @(posedge clk) begin
        res_t got;
        res_t want;
        bit   moved;
        moved      = 1'b0;
        char_taken = s_tvalid && s_tready;
        if (char_taken) begin
            moved = 1'b1;
            chars_taken++;
            if (parse_char(s_tdata, want))
                due_results.push_back(want);
        end
        if (m_tvalid && m_tready) begin
            moved = 1'b1;
            got   = m_tdata[$bits(res_t)-1:0];
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h end %0d ovf %b bad %b",
                             got.value, got.end_offset, got.overflowed, got.bad_base);
            end
            else begin
                want = due_results.pop_front();
                if (got.value !== want.value || got.end_offset !== want.end_offset ||
                    got.overflowed !== want.overflowed || got.bad_base !== want.bad_base ||
                    m_tdata[M_TDATA_W-1:$bits(res_t)] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected value %h end %0d ovf %b bad %b,",
                                  " got value %h end %0d ovf %b bad %b pad %b"},
                                 want.value, want.end_offset, want.overflowed, want.bad_base,
                                 got.value, got.end_offset, got.overflowed, got.bad_base,
                                 m_tdata[M_TDATA_W-1:$bits(res_t)]);
                end
            end
        end
        // Watchdog: only count while something is still owed
        if (moved || (chars_queued == chars_taken && due_results.size() == 0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_char(input logic [CH_W-1:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    // Queue a string and its terminator
    task automatic push_text(input string s);
        foreach (s[i])
            push_char(s[i]);
        push_char(CH_NUL);
    endtask

    function automatic logic [CH_W-1:0] digit_char(input int unsigned d);
        if (d < 10)
            return CH_W'(8'h30 + d);
        return CH_W'(($urandom_range(1) ? 8'h41 : 8'h61) + d - 10);
    endfunction

    // Write one register while the parser is idle; keep the image in step
    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RADIX)
            cfg_radix = data[BASE_W-1:0];
        else
            cfg_kind = data[KIND_W-1:0];
    endtask

    // Hold until every character is taken and every result has come, then settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (chars_queued != chars_taken || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Well-formed number with random content, mostly in the configured base
    task automatic queue_number(input logic [BASE_W-1:0] rbase);
        int unsigned base;
        int unsigned nd;
        int unsigned d;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) push_char(blanks[$urandom_range(5)]);
        case ($urandom_range(3))
            0:       push_char(CH_PLUS);
            1:       push_char(CH_MINUS);
            default: ;
        endcase
        base = 32'(rbase);
        if (rbase == BASE_AUTO || rbase == BASE_HEX) begin
            case ($urandom_range(3))
                0: begin
                    push_char(CH_ZERO);
                    push_char($urandom_range(1) ? CH_LX : CH_UX);
                    base = BASE_HEX;
                end
                1: begin
                    if (rbase == BASE_AUTO) begin
                        push_char(CH_ZERO);
                        base = BASE_OCT;
                    end
                end
                default: ;
            endcase
            if (base == BASE_AUTO)
                base = BASE_DEC;
        end
        if (base < 2 || base > BASE_MAX)
            base = BASE_DEC;
        // long runs push the accumulator into saturation
        nd = ($urandom_range(4) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 8);
        if ($urandom_range(15) == 0)
            nd = 0;
        repeat (nd) begin
            d = ($urandom_range(7) == 0) ? base - 1 : $urandom_range(base - 1);
            push_char(digit_char(d));
        end
        // end the number on the terminator or on junk followed by a tail
        if ($urandom_range(1)) begin
            push_char(CH_W'($urandom_range(1, 255)));
            repeat ($urandom_range(3)) push_char(CH_W'($urandom_range(1, 255)));
        end
        push_char(CH_NUL);
    endtask

    // Noise and broken sequences: signs, zeros, prefixes, blanks and any byte
    task automatic queue_noise();
        logic [CH_W-1:0] parts[6];
        parts = '{CH_PLUS, CH_MINUS, CH_ZERO, CH_LX, CH_UX, CH_SPACE};
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1))
                push_char(parts[$urandom_range(5)]);
            else
                push_char(CH_W'($urandom_range(1, 255)));
        end
        push_char(CH_NUL);
    endtask

    task automatic set_idling(input int unsigned mode);
        case (mode)
            0: begin
                send_idle_pct = 13;
                recv_idle_pct = 66;
            end
            1: begin
                send_idle_pct = 66;
                recv_idle_pct = 13;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial begin : stimulus
        logic [BASE_W-1:0] radix_list[12];
        logic [KIND_W-1:0] kind_list[12];
        logic [BASE_W-1:0] rb;
        logic [KIND_W-1:0] rk;
        int unsigned       start;
        radix_list = '{6'd0, 6'd10, 6'd16, 6'd2, 6'd36, 6'd8, 6'd1, 6'd0, 6'd63, 6'd0,
                       6'd16, 6'd36};
        kind_list  = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1,
                       2'd0, 2'd2};
        clear_parse();
        set_idling(0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at reset settings: blanks, sign and hex prefix in
        // automatic mode, prefix with no hex digit, octal, empty string, top byte
        @(posedge clk);
        push_text(" -0x1F");
        push_text("0xg");
        push_text("017");
        push_text("");
        push_char(8'hFF);
        push_char(CH_NUL);
        wait_drained();
        // illegal base of one
        write_reg(REG_RADIX, 32'd1);
        @(posedge clk);
        push_text("5");
        wait_drained();
        // minus in the unsigned kind
        write_reg(REG_RADIX, 32'd10);
        write_reg(REG_KIND, 32'd2);
        @(posedge clk);
        push_text("-5");
        wait_drained();

        // Random phases: fixed settings first, then random ones over the full fields
        for (int unsigned p = 0; p < 15; p++) begin
            if (p < 12) begin
                rb = radix_list[p];
                rk = kind_list[p];
            end
            else begin
                rb = BASE_W'($urandom_range(63));
                rk = KIND_W'($urandom_range(3));
            end
            write_reg(REG_RADIX, 32'(rb));
            write_reg(REG_KIND, 32'(rk));
            @(posedge clk);
            set_idling(p / 5);
            start = chars_queued;
            while (chars_queued - start < PHASE_CHARS) begin
                if ($urandom_range(99) < 80)
                    queue_number(rb);
                else
                    queue_noise();
            end
            wait_drained();
        end

        // Long string: a run of blanks ahead of a signed number
        write_reg(REG_RADIX, 32'd10);
        write_reg(REG_KIND, 32'd1);
        @(posedge clk);
        repeat (LONG_BLANKS) push_char(blanks[$urandom_range(5)]);
        push_text("-12345");
        wait_drained();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
